// File: design/dmseq_pkg.sv
package dmseq_pkg;

    localparam int MOTION_COUNT_DEF = 8;
    localparam int TIME_BITS_DEF    = 32;

    localparam int CMD_W  = 4;
    localparam int DUR_W  = 32;
    localparam int PCT_W  = 7;
    localparam int PINS_W = 4;
    localparam int TOT_W  = 32;
    localparam int CFG_W  = 2;

    localparam logic [PCT_W-1:0] PCT_MAX          = 7'd100;
    localparam logic [PCT_W-1:0] FORWARD_PCT_RST  = 7'd75;
    localparam logic [PCT_W-1:0] BACKWARD_PCT_RST = 7'd50;
    localparam logic [PCT_W-1:0] SPIN_PCT_RST     = 7'd40;

    typedef enum logic [CMD_W-1:0] {
        CMD_HALT      = 4'd0,
        CMD_FWD       = 4'd1,
        CMD_BWD       = 4'd2,
        CMD_SPIN_R    = 4'd3,
        CMD_SPIN_L    = 4'd4,
        CMD_PIV_FR    = 4'd5,
        CMD_PIV_FL    = 4'd6,
        CMD_PIV_BR    = 4'd7,
        CMD_PIV_BL    = 4'd8,
        CMD_TICK      = 4'd9,
        CMD_QUERY     = 4'd10
    } t_cmd;

    typedef enum logic [CFG_W-1:0] {
        CFG_FORWARD  = 2'd0,
        CFG_BACKWARD = 2'd1,
        CFG_SPIN     = 2'd2
    } t_cfg_idx;

    // Totals store operation for one item: read-modify-write or query read.
    typedef struct packed {
        logic             wr;
        logic             qry;
        logic [CMD_W-1:0] code;
    } t_mem_op;

    function automatic logic [PINS_W-1:0] pins_for(input logic [CMD_W-1:0] m);
        logic [PINS_W-1:0] p;
        unique case (m)
            CMD_FWD:    p = 4'd5;
            CMD_BWD:    p = 4'd10;
            CMD_SPIN_R: p = 4'd6;
            CMD_SPIN_L: p = 4'd9;
            CMD_PIV_FR: p = 4'd4;
            CMD_PIV_FL: p = 4'd1;
            CMD_PIV_BR: p = 4'd8;
            CMD_PIV_BL: p = 4'd2;
            default:    p = 4'd0;
        endcase
        return p;
    endfunction

    function automatic logic [PCT_W-1:0] clip_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

endpackage

// File: design/dmseq_if.sv
interface dmseq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dmseq_pkg::CMD_W-1:0]   command;
    logic [dmseq_pkg::DUR_W-1:0]   duration_ms;
    logic [dmseq_pkg::CMD_W-1:0]   query_motion;

    modport source (output valid, command, duration_ms, query_motion, input ready);
    modport sink   (input valid, command, duration_ms, query_motion, output ready);
endinterface

interface dmseq_res_if;
    logic                          valid;
    logic                          ready;
    logic [dmseq_pkg::PINS_W-1:0]  bridge_pins;
    logic [dmseq_pkg::PCT_W-1:0]   right_speed_pct;
    logic [dmseq_pkg::PCT_W-1:0]   left_speed_pct;
    logic [dmseq_pkg::CMD_W-1:0]   motion_now;
    logic [dmseq_pkg::TOT_W-1:0]   time_total_ms;
    logic                          timed_out;

    modport source (output valid, bridge_pins, right_speed_pct, left_speed_pct, motion_now,
                    time_total_ms, timed_out, input ready);
    modport sink   (input valid, bridge_pins, right_speed_pct, left_speed_pct, motion_now,
                    time_total_ms, timed_out, output ready);
endinterface

interface dmseq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dmseq_pkg::CFG_W-1:0]   index;
    logic [dmseq_pkg::PCT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/differential_drive_motion_sequencer.sv
// Differential-drive motion sequencer: drives a two-wheel H-bridge.
//
// Channels:
//   i_cmd  - command transfers: halt, eight motions, millisecond tick, query.
//   o_res  - one result transfer per command: bridge pins, wheel speeds,
//            current motion, queried time total and a deadline-expiry flag.
//   i_cfg  - register writes (0 forward, 1 backward, 2 spin percent); always
//            ready, other indexes are dropped. Write only while idle.
// Path: a command moves from the transfer into stage 1, then into the
//   output register, which drives o_res.valid; a stall can hold it there.
// Throughput: one command per cycle while o_res is not stalled. Motion
//   state sits in registers; the per-motion totals sit in a small memory
//   with a registered read as the command is taken, written back one stage
//   later, forwarding a write to a same-entry read in the same cycle.
// Reset: motion halted, deadline expired, registers at 75/50/40 percent,
//   all totals read as zero (one valid bit per entry, no clearing pass).
// Stall: a result held on o_res keeps one more command in stage 1; after
//   that i_cmd.ready drops until the receiver takes the result.
module differential_drive_motion_sequencer #(
    parameter int MOTION_COUNT = dmseq_pkg::MOTION_COUNT_DEF,
    parameter int TIME_BITS    = dmseq_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmseq_cmd_if.sink   i_cmd,
    dmseq_res_if.source o_res,
    dmseq_cfg_if.sink   i_cfg
);
    import dmseq_pkg::*;

    // configuration registers
    logic [PCT_W-1:0] r_fwd_pct;
    logic [PCT_W-1:0] r_bwd_pct;
    logic [PCT_W-1:0] r_spin_pct;

    // handshake
    logic w_accept;
    logic w_advance;

    // core to store
    t_mem_op              w_op;
    logic [TIME_BITS-1:0] w_add;
    logic [CMD_W-1:0]     w_motion_next;
    logic                 w_timed;
    logic                 w_qry;
    logic [TIME_BITS-1:0] w_sum;
    logic [63:0]          w_sum_ext;

    // stage 1
    logic             r_s1_valid;
    logic [CMD_W-1:0] r_s1_motion;
    logic             r_s1_timed;

    // output register
    logic             r_out_valid;
    logic [PINS_W-1:0] r_out_pins;
    logic [PCT_W-1:0] r_out_right;
    logic [PCT_W-1:0] r_out_left;
    logic [CMD_W-1:0] r_out_motion;
    logic [TOT_W-1:0] r_out_total;
    logic             r_out_timed;

    logic [PCT_W-1:0] w_f;
    logic [PCT_W-1:0] w_b;
    logic [PCT_W-1:0] w_s;
    logic [PCT_W-1:0] w_right;
    logic [PCT_W-1:0] w_left;

    // stage 1 moves on when the output register is free or being emptied
    assign w_advance   = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_s1_valid || w_advance;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_pct  <= FORWARD_PCT_RST;
            r_bwd_pct  <= BACKWARD_PCT_RST;
            r_spin_pct <= SPIN_PCT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FORWARD:  r_fwd_pct  <= i_cfg.data;
                CFG_BACKWARD: r_bwd_pct  <= i_cfg.data;
                CFG_SPIN:     r_spin_pct <= i_cfg.data;
                default:      r_fwd_pct  <= r_fwd_pct;
            endcase
        end
    end

    dmseq_core #(
        .MOTION_COUNT (MOTION_COUNT),
        .TIME_BITS    (TIME_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_command      (i_cmd.command),
        .i_duration_ms  (i_cmd.duration_ms),
        .i_query_motion (i_cmd.query_motion),
        .o_op           (w_op),
        .o_add          (w_add),
        .o_motion_next  (w_motion_next),
        .o_timed        (w_timed)
    );

    dmseq_store #(
        .MOTION_COUNT (MOTION_COUNT),
        .TIME_BITS    (TIME_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_op      (w_op),
        .i_add     (w_add),
        .i_advance (w_advance),
        .o_qry     (w_qry),
        .o_sum     (w_sum)
    );

    // stage 1: hold the post-command motion while the totals read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_motion <= w_motion_next;
            r_s1_timed  <= w_timed;
        end
    end

    // wheel speeds from the live register values, clipped to 100
    assign w_f = clip_pct(r_fwd_pct);
    assign w_b = clip_pct(r_bwd_pct);
    assign w_s = clip_pct(r_spin_pct);

    always_comb begin
        w_right = '0;
        w_left  = '0;
        unique case (r_s1_motion)
            CMD_FWD:    begin w_right = w_f; w_left = w_f; end
            CMD_BWD:    begin w_right = w_b; w_left = w_b; end
            CMD_SPIN_R: begin w_right = w_s; w_left = w_s; end
            CMD_SPIN_L: begin w_right = w_s; w_left = w_s; end
            CMD_PIV_FR: begin w_right = '0;  w_left = w_f; end
            CMD_PIV_FL: begin w_right = w_f; w_left = '0;  end
            CMD_PIV_BR: begin w_right = '0;  w_left = w_b; end
            CMD_PIV_BL: begin w_right = w_b; w_left = '0;  end
            default:    begin w_right = '0;  w_left = '0;  end
        endcase
    end

    assign w_sum_ext = 64'(w_sum);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_pins   <= pins_for(r_s1_motion);
            r_out_right  <= w_right;
            r_out_left   <= w_left;
            r_out_motion <= r_s1_motion;
            r_out_total  <= w_qry ? w_sum_ext[TOT_W-1:0] : '0;
            r_out_timed  <= r_s1_timed;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.bridge_pins     = r_out_pins;
    assign o_res.right_speed_pct = r_out_right;
    assign o_res.left_speed_pct  = r_out_left;
    assign o_res.motion_now      = r_out_motion;
    assign o_res.time_total_ms   = r_out_total;
    assign o_res.timed_out       = r_out_timed;

`ifndef SYNTHESIS
    // an expiry always leaves the drive halted
    a_timed_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.timed_out |-> o_res.motion_now == CMD_HALT)
        else $error("timed_out with a running motion");

    // only a query carries a time total
    a_total_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_qry |=> o_res.time_total_ms == '0)
        else $error("time total on a non-query result");

    // the motion code stays within the configured set
    a_motion_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.motion_now <= CMD_W'(MOTION_COUNT))
        else $error("motion code out of range");
`endif

endmodule

// File: design/dmseq_core.sv
module dmseq_core #(
    parameter int MOTION_COUNT = dmseq_pkg::MOTION_COUNT_DEF,
    parameter int TIME_BITS    = dmseq_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dmseq_pkg::CMD_W-1:0]   i_command,
    input  logic [dmseq_pkg::DUR_W-1:0]   i_duration_ms,
    input  logic [dmseq_pkg::CMD_W-1:0]   i_query_motion,
    output dmseq_pkg::t_mem_op            o_op,
    output logic [TIME_BITS-1:0]          o_add,
    output logic [dmseq_pkg::CMD_W-1:0]   o_motion_next,
    output logic                          o_timed
);
    import dmseq_pkg::*;

    localparam logic [CMD_W-1:0] MOTION_LAST = CMD_W'(MOTION_COUNT);

    logic [CMD_W-1:0]     r_motion,  n_motion;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic [TIME_BITS-1:0] w_el_inc;
    logic [TIME_BITS-1:0] w_dl_dec;
    logic [63:0]          w_dur_ext;
    logic                 w_is_motion;

    assign w_dur_ext   = 64'(i_duration_ms);
    assign w_el_inc    = r_elapsed + TIME_BITS'(1);
    assign w_dl_dec    = (r_deadline != '0) ? (r_deadline - TIME_BITS'(1)) : r_deadline;
    assign w_is_motion = (i_command >= CMD_FWD) && (i_command <= CMD_PIV_BL)
                         && (i_command <= MOTION_LAST);

    always_comb begin
        n_motion   = r_motion;
        n_elapsed  = r_elapsed;
        n_deadline = r_deadline;
        o_op       = '0;
        o_add      = r_elapsed;
        o_timed    = 1'b0;
        priority if (i_command == CMD_HALT) begin
            if (r_motion != CMD_HALT) begin
                o_op.wr   = 1'b1;
                o_op.code = r_motion;
                n_motion  = CMD_HALT;
                n_elapsed = '0;
            end
        end else if (w_is_motion) begin
            if (r_motion != i_command) begin
                o_op.wr   = (r_motion != CMD_HALT);
                o_op.code = r_motion;
                n_motion  = i_command;
                n_elapsed = '0;
            end
            if (i_duration_ms != '0) begin
                n_deadline = w_dur_ext[TIME_BITS-1:0];
            end
        end else if (i_command == CMD_TICK) begin
            n_deadline = w_dl_dec;
            if ((w_dl_dec == '0) && (r_motion != CMD_HALT)) begin
                // deadline expired: fold the running interval into its total
                o_op.wr   = 1'b1;
                o_op.code = r_motion;
                o_add     = w_el_inc;
                n_motion  = CMD_HALT;
                n_elapsed = '0;
                o_timed   = 1'b1;
            end else begin
                n_elapsed = w_el_inc;
            end
        end else if (i_command == CMD_QUERY) begin
            if ((i_query_motion != CMD_HALT) && (i_query_motion <= MOTION_LAST)) begin
                o_op.qry  = 1'b1;
                o_op.code = i_query_motion;
                o_add     = (r_motion == i_query_motion) ? r_elapsed : '0;
            end
        end else begin
            n_motion = r_motion;
        end
    end

    assign o_motion_next = n_motion;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion   <= CMD_HALT;
            r_elapsed  <= '0;
            r_deadline <= '0;
        end else if (i_accept) begin
            r_motion   <= n_motion;
            r_elapsed  <= n_elapsed;
            r_deadline <= n_deadline;
        end
    end

endmodule

// File: design/dmseq_store.sv
module dmseq_store #(
    parameter int MOTION_COUNT = dmseq_pkg::MOTION_COUNT_DEF,
    parameter int TIME_BITS    = dmseq_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  dmseq_pkg::t_mem_op    i_op,
    input  logic [TIME_BITS-1:0]  i_add,
    input  logic                  i_advance,
    output logic                  o_qry,
    output logic [TIME_BITS-1:0]  o_sum
);
    import dmseq_pkg::*;

    localparam int IDX_W = (MOTION_COUNT > 1) ? $clog2(MOTION_COUNT) : 1;
    localparam logic [CMD_W-1:0] MOTION_LAST = CMD_W'(MOTION_COUNT);

    logic [TIME_BITS-1:0] r_mem [MOTION_COUNT];
    logic [MOTION_COUNT-1:0] r_vld;

    logic [TIME_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic                 r_fwd_hit;
    logic [TIME_BITS-1:0] r_fwd_data;
    t_mem_op              r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_add;

    logic [CMD_W-1:0]     w_code_m1;
    logic [IDX_W-1:0]     w_rd_idx;
    logic                 w_wr_now;
    logic [TIME_BITS-1:0] w_base;

    assign w_code_m1 = i_op.code - CMD_W'(1);
    assign w_rd_idx  = ((i_op.code != CMD_HALT) && (i_op.code <= MOTION_LAST))
                       ? w_code_m1[IDX_W-1:0] : '0;

    // the stage-1 item updates its entry as it moves to the output register
    assign w_wr_now = i_advance && r_op.wr;

    // an entry never written reads as zero through its cleared valid bit
    assign w_base = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
    assign o_sum  = w_base + r_add;
    assign o_qry  = r_op.qry;

    always_ff @(posedge i_clk) begin
        if (w_wr_now) begin
            r_mem[r_idx] <= o_sum;
        end
        if (i_accept) begin
            r_rd_data  <= r_mem[w_rd_idx];
            r_fwd_hit  <= w_wr_now && (r_idx == w_rd_idx);
            r_fwd_data <= o_sum;
            r_op       <= i_op;
            r_idx      <= w_rd_idx;
            r_add      <= i_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr_now) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (i_accept) begin
                r_rd_vld <= r_vld[w_rd_idx];
            end
        end
    end

endmodule

// File: test/differential_drive_motion_sequencer_test.sv
`timescale 1ns / 1ps

module differential_drive_motion_sequencer_test;

    import dmseq_pkg::*;

    // Run shape: drain slack covers the command-to-result latency, and the
    // watchdog ends the run when no channel moves a transfer within its limit.
    localparam int DRAIN_SLACK     = 4;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SEGMENTS        = 6;
    localparam int SEGMENT_ITEMS   = 75;
    localparam int HOLD_OFF_CYCLES = 64;

    // Codes outside the command and motion sets; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_UNUSED_BASE = 4'd11;
    localparam logic [CMD_W-1:0] CMD_UNUSED_TOP  = 4'd15;
    localparam logic [CMD_W-1:0] QM_PAST_END     = 4'd9;
    localparam logic [CMD_W-1:0] QM_TOP          = 4'd15;
    localparam logic [CFG_W-1:0] CFG_UNUSED      = 2'd3;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic [PCT_W-1:0]  right_pct;
        logic [PCT_W-1:0]  left_pct;
        logic [CMD_W-1:0]  motion;
        logic [TOT_W-1:0]  total;
        logic              timed;
    } t_drive_result;

    // A hand-written answer that replaces the predicted one for a script row.
    typedef struct packed {
        logic          known;
        t_drive_result res;
    } t_typed_answer;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [DUR_W-1:0] dur;
        logic [CMD_W-1:0] qm;
        logic             known;
        t_drive_result    res;
    } t_script_row;

    localparam t_drive_result RES_HALTED = '0;
    localparam t_drive_result RES_EXPIRED = '{4'b0000, 7'd0, 7'd0, CMD_HALT, 32'd0, 1'b1};
    localparam t_drive_result RES_ONE_MS_FWD = '{4'b0000, 7'd0, 7'd0, CMD_HALT, 32'd1, 1'b0};
    localparam t_drive_result RES_FWD_DEFAULT =
        '{4'b0101, FORWARD_PCT_RST, FORWARD_PCT_RST, CMD_FWD, 32'd0, 1'b0};
    localparam t_drive_result RES_BWD_DEFAULT =
        '{4'b1010, BACKWARD_PCT_RST, BACKWARD_PCT_RST, CMD_BWD, 32'd0, 1'b0};

    // Directed script, run with the speed registers at their reset values.
    // Rows with known = 0 are checked against the predictor.
    localparam int SCRIPT_ROWS = 26;
    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        // fresh from reset: halted, deadline expired, all totals zero
        '{CMD_QUERY,      32'd0,         CMD_FWD,     1'b1, RES_HALTED},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b1, RES_HALTED},
        // zero duration on an expired deadline: halts on the very next tick
        '{CMD_FWD,        32'd0,         CMD_HALT,    1'b1, RES_FWD_DEFAULT},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b1, RES_EXPIRED},
        '{CMD_QUERY,      32'd0,         CMD_FWD,     1'b1, RES_ONE_MS_FWD},
        // walk the other seven motions, with a full-scale deadline in between
        '{CMD_BWD,        32'd3,         CMD_HALT,    1'b1, RES_BWD_DEFAULT},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_SPIN_R,     32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_SPIN_L,     32'hFFFF_FFFF, CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_PIV_FR,     32'd5,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_PIV_FL,     32'd1,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_PIV_BR,     32'd2,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_PIV_BL,     32'd2,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        // query the running motion: total plus the open interval
        '{CMD_QUERY,      32'd0,         CMD_PIV_BL,  1'b0, RES_HALTED},
        // reselect the running motion with zero duration: nothing changes
        '{CMD_PIV_BL,     32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        // queries out of range answer zero; unused commands are ignored
        '{CMD_QUERY,      32'd0,         CMD_HALT,    1'b1, RES_HALTED},
        '{CMD_QUERY,      32'd0,         QM_PAST_END, 1'b1, RES_HALTED},
        '{CMD_UNUSED_TOP, 32'hFFFF_FFFF, QM_TOP,      1'b1, RES_HALTED},
        '{CMD_HALT,       32'd0,         CMD_HALT,    1'b1, RES_HALTED},
        // halt keeps the deadline, so the following tick only counts down
        '{CMD_FWD,        32'd10,        CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_HALT,       32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_TICK,       32'd0,         CMD_HALT,    1'b0, RES_HALTED},
        '{CMD_QUERY,      32'd0,         CMD_BWD,     1'b0, RES_HALTED}
    };

    logic i_clk;
    logic i_rst_n;

    dmseq_cmd_if cmd_bus ();
    dmseq_res_if res_bus ();
    dmseq_cfg_if cfg_bus ();

    differential_drive_motion_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Drive model state: speed registers, current motion, open interval,
    // deadline countdown and the per-motion totals.
    logic [PCT_W-1:0] pct_fwd  = FORWARD_PCT_RST;
    logic [PCT_W-1:0] pct_bwd  = BACKWARD_PCT_RST;
    logic [PCT_W-1:0] pct_spin = SPIN_PCT_RST;
    logic [CMD_W-1:0] drive_motion = CMD_HALT;
    logic [TOT_W-1:0] drive_elapsed = '0;
    logic [DUR_W-1:0] drive_deadline = '0;
    logic [TOT_W-1:0] motion_totals [1:MOTION_COUNT_DEF];

    t_drive_result pending_results [$];
    t_typed_answer typed_answers [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_request;
    int idle_cycles;
    int failures;
    int items_taken;
    int results_seen;
    int reg_writes;

    function automatic logic [PCT_W-1:0] capped(input logic [PCT_W-1:0] v);
        return (v > 7'd100) ? 7'd100 : v;
    endfunction

    // Close the open interval into the old motion's total, then switch.
    function automatic void change_motion(input logic [CMD_W-1:0] next);
        if (drive_motion != CMD_HALT)
            motion_totals[drive_motion] = motion_totals[drive_motion] + drive_elapsed;
        drive_motion  = next;
        drive_elapsed = '0;
    endfunction

    // Apply one command to the drive model and return what the block reports.
    function automatic t_drive_result apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [DUR_W-1:0] dur,
                                                    input logic [CMD_W-1:0] qm);
        t_drive_result r;
        logic [PCT_W-1:0] f;
        logic [PCT_W-1:0] b;
        logic [PCT_W-1:0] s;
        r = '0;
        if (cmd == CMD_HALT) begin
            if (drive_motion != CMD_HALT) change_motion(CMD_HALT);
        end else if (cmd >= CMD_FWD && cmd <= CMD_PIV_BL) begin
            if (drive_motion != cmd) change_motion(cmd);
            if (dur != '0) drive_deadline = dur;
        end else if (cmd == CMD_TICK) begin
            drive_elapsed = drive_elapsed + 1'b1;
            if (drive_deadline != '0) drive_deadline = drive_deadline - 1'b1;
            if (drive_deadline == '0 && drive_motion != CMD_HALT) begin
                change_motion(CMD_HALT);
                r.timed = 1'b1;
            end
        end else if (cmd == CMD_QUERY) begin
            if (qm >= CMD_FWD && qm <= CMD_PIV_BL) begin
                r.total = motion_totals[qm];
                if (drive_motion == qm) r.total = r.total + drive_elapsed;
            end
        end

        // Speeds follow the live register values, capped at full scale.
        f = capped(pct_fwd);
        b = capped(pct_bwd);
        s = capped(pct_spin);
        case (drive_motion)
            CMD_FWD:    begin r.pins = 4'b0101; r.right_pct = f;  r.left_pct = f;  end
            CMD_BWD:    begin r.pins = 4'b1010; r.right_pct = b;  r.left_pct = b;  end
            CMD_SPIN_R: begin r.pins = 4'b0110; r.right_pct = s;  r.left_pct = s;  end
            CMD_SPIN_L: begin r.pins = 4'b1001; r.right_pct = s;  r.left_pct = s;  end
            CMD_PIV_FR: begin r.pins = 4'b0100; r.right_pct = '0; r.left_pct = f;  end
            CMD_PIV_FL: begin r.pins = 4'b0001; r.right_pct = f;  r.left_pct = '0; end
            CMD_PIV_BR: begin r.pins = 4'b1000; r.right_pct = '0; r.left_pct = b;  end
            CMD_PIV_BL: begin r.pins = 4'b0010; r.right_pct = b;  r.left_pct = '0; end
            default:    r.pins = 4'b0000;
        endcase
        r.motion = drive_motion;
        return r;
    endfunction

    // Clock: 8 ns period.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result receiver: stall at random, or hold off for a long stretch when
    // asked, so the block backs up and drops its command ready.
    initial begin
        int held;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                res_bus.ready <= 1'b0;
                for (held = 0; held < hold_request; held++) @(posedge i_clk);
                hold_request = 0;
            end
            res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: track register writes, predict on every command transfer,
    // check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_drive_result want;
        t_drive_result got;
        t_typed_answer note;
        if (i_rst_n) begin
            idle_cycles++;

            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_FORWARD:  pct_fwd  = cfg_bus.data;
                    CFG_BACKWARD: pct_bwd  = cfg_bus.data;
                    CFG_SPIN:     pct_spin = cfg_bus.data;
                    default:      ;
                endcase
                reg_writes++;
                idle_cycles = 0;
            end

            if (cmd_bus.valid && cmd_bus.ready) begin
                want = apply_command(cmd_bus.command, cmd_bus.duration_ms,
                                     cmd_bus.query_motion);
                if (typed_answers.size() != 0) begin
                    note = typed_answers.pop_front();
                    if (note.known) want = note.res;
                end
                pending_results.push_back(want);
                items_taken++;
                idle_cycles = 0;
            end

            if (res_bus.valid && res_bus.ready) begin
                got.pins      = res_bus.bridge_pins;
                got.right_pct = res_bus.right_speed_pct;
                got.left_pct  = res_bus.left_speed_pct;
                got.motion    = res_bus.motion_now;
                got.total     = res_bus.time_total_ms;
                got.timed     = res_bus.timed_out;
                if (pending_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = pending_results.pop_front();
                    if (got.pins !== want.pins || got.right_pct !== want.right_pct ||
                        got.left_pct !== want.left_pct || got.motion !== want.motion ||
                        got.total !== want.total || got.timed !== want.timed) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("result %0d (expected/actual): pins %b/%b right %0d/%0d",
                                     results_seen, want.pins, got.pins,
                                     want.right_pct, got.right_pct);
                            $display("  left %0d/%0d motion %0d/%0d total %0d/%0d timed %b/%b",
                                     want.left_pct, got.left_pct, want.motion, got.motion,
                                     want.total, got.total, want.timed, got.timed);
                        end
                    end
                end
                results_seen++;
                idle_cycles = 0;
            end
        end
    end

    // Watchdog: end the run if no channel moves a transfer for too long.
    initial begin
        while (idle_cycles < WATCHDOG_CYCLES) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one command, with a random gap first; return at the edge that
    // takes it. Valid stays high straight into the next command when no gap.
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [DUR_W-1:0] dur,
                              input logic [CMD_W-1:0] qm, input logic known,
                              input t_drive_result res);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.command      <= cmd;
        cmd_bus.duration_ms  <= dur;
        cmd_bus.query_motion <= qm;
        typed_answers.push_back('{known, res});
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    // Wait until every expected result is back, then let the pipe empty.
    // Step one edge first so the monitor has logged the last transfer.
    task automatic settle_idle();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [PCT_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_speeds(input logic [PCT_W-1:0] f, input logic [PCT_W-1:0] b,
                               input logic [PCT_W-1:0] s);
        settle_idle();
        write_reg(CFG_FORWARD, f);
        write_reg(CFG_BACKWARD, b);
        write_reg(CFG_SPIN, s);
    endtask

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [DUR_W-1:0] dur;
        logic [CMD_W-1:0] qm;
        int pick;
        int seg;
        int taken;
        int row;

        foreach (motion_totals[m]) motion_totals[m] = '0;
        tx_idle_pct  = 27;
        rx_idle_pct  = 55;
        hold_request = 0;
        idle_cycles  = 0;
        failures     = 0;
        items_taken  = 0;
        results_seen = 0;
        reg_writes   = 0;

        // Hold every input at a known value through reset.
        i_rst_n              <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.command      <= CMD_HALT;
        cmd_bus.duration_ms  <= '0;
        cmd_bus.query_motion <= CMD_HALT;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= CFG_FORWARD;
        cfg_bus.data         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script on the reset register values.
        for (row = 0; row < SCRIPT_ROWS; row++)
            offer_item(SCRIPT[row].cmd, SCRIPT[row].dur, SCRIPT[row].qm,
                       SCRIPT[row].known, SCRIPT[row].res);
        cmd_bus.valid <= 1'b0;

        // Random segments: each starts from a new register setting, and the
        // idle mix moves from sender-light to receiver-light to none.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: load_speeds(7'd0, 7'd127, 7'd100);
                1: begin
                    load_speeds(7'd100, 7'd0, 7'd127);
                    write_reg(CFG_UNUSED, 7'h7F);    // dropped by the block
                end
                3: load_speeds(7'd127, 7'd100, 7'd0);
                default: load_speeds(PCT_W'($urandom_range(127)), PCT_W'($urandom_range(127)),
                                     PCT_W'($urandom_range(127)));
            endcase

            case (seg / 2)
                0:       begin tx_idle_pct = 27; rx_idle_pct = 55; end
                1:       begin tx_idle_pct = 55; rx_idle_pct = 27; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // Back the block up once while commands keep coming.
            if (seg == 4) hold_request = HOLD_OFF_CYCLES;

            // Mostly motions with short deadlines followed by ticks and
            // queries, so deadlines expire and totals build up; the rest is
            // halts, out-of-range queries and unused commands.
            taken = 0;
            while (taken < SEGMENT_ITEMS) begin
                pick = $urandom_range(99);
                dur  = $urandom;
                qm   = CMD_W'($urandom_range(15));
                if (pick < 35) begin
                    cmd = CMD_TICK;
                end else if (pick < 60) begin
                    cmd  = CMD_W'($urandom_range(CMD_PIV_BL, CMD_FWD));
                    pick = $urandom_range(99);
                    if (pick < 30) dur = '0;
                    else if (pick < 80) dur = $urandom_range(24, 1);
                    else if (pick < 85) dur = '1;
                end else if (pick < 70) begin
                    cmd = CMD_HALT;
                end else if (pick < 93) begin
                    cmd = CMD_QUERY;
                    if ($urandom_range(3) != 0)
                        qm = CMD_W'($urandom_range(CMD_PIV_BL, CMD_FWD));
                end else begin
                    cmd = CMD_W'($urandom_range(CMD_UNUSED_TOP, CMD_UNUSED_BASE));
                end
                offer_item(cmd, dur, qm, 1'b0, RES_HALTED);
                taken++;
            end
            cmd_bus.valid <= 1'b0;
        end

        settle_idle();

        $display("Ran %0d commands (%0d scripted) and checked %0d results over %0d speed",
                 items_taken, SCRIPT_ROWS, results_seen, reg_writes);
        $display("register writes, three handshake mixes and one long result stall.");
        failures += pending_results.size();
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/dmseq_pkg.sv
design/dmseq_if.sv
design/dmseq_core.sv
design/dmseq_store.sv
design/differential_drive_motion_sequencer.sv
test/differential_drive_motion_sequencer_test.sv
